// ===== rtl/core/gesn_pkg.sv =====
// Package: shared constants, codes and controller/datapath types of the edge normalizer.
`default_nettype none
package gesn_pkg;

  localparam int DefMaxVertices = 1024;
  localparam int DefIdBits      = 32;

  localparam int VcountWidth = 11;
  localparam int RawWidth    = 32;
  localparam int OutVxWidth  = 10;
  localparam int TotalWidth  = 32;
  localparam int WordBits    = 64;
  localparam int WordShift   = 6;

  localparam logic [VcountWidth-1:0] VcountReset = 11'd1024;

  // Input function codes
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_END    = 2'd1;
  localparam logic [1:0] FUNC_FETCH  = 2'd2;

  // Result codes
  localparam logic [1:0] RES_EDGE    = 2'd0;
  localparam logic [1:0] RES_SUMMARY = 2'd1;
  localparam logic [1:0] RES_NOMORE  = 2'd2;
  localparam logic [1:0] RES_REJECT  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_VCOUNT = 2'd0;
  localparam logic [1:0] REG_STATIC = 2'd1;
  localparam logic [1:0] REG_CHECK  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_IDLE,
    OP_SINIT,
    OP_SRD,
    OP_SCMP,
    OP_REJECT,
    OP_ASGS,
    OP_ASGT,
    OP_ORDER,
    OP_MUL,
    OP_IDX,
    OP_PRD,
    OP_PMOD,
    OP_END,
    OP_NOMORE,
    OP_FREAD,
    OP_FTEST,
    OP_CONV,
    OP_EMIT
  } gesn_op_t;

  typedef struct packed {
    gesn_op_t op;
  } gesn_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       ended;
    logic       static_mode;
    logic       clr_last;
    logic       search_done;
    logic       fail;
    logic       same;
    logic       scan_done;
    logic       word_hit;
    logic       row_last;
    logic       conv_step;
    logic       out_free;
  } gesn_status_t;

  typedef struct packed {
    logic [VcountWidth-1:0] vertex_count;
    logic                   static_mode;
    logic                   check_types;
  } gesn_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/gesn_if.sv =====
// Interfaces: input item channel and result channel with valid/ready handshake.
`default_nettype none
interface gesn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  update_kind;
  logic [31:0] raw_source;
  logic [31:0] raw_target;
  modport source (output valid, func, update_kind, raw_source, raw_target, input ready);
  modport sink   (input valid, func, update_kind, raw_source, raw_target, output ready);
endinterface

interface gesn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        edge_kind;
  logic [9:0]  low_vertex;
  logic [9:0]  high_vertex;
  logic        mismatch;
  logic [31:0] edge_total;
  modport source (output valid, result_kind, edge_kind, low_vertex, high_vertex, mismatch,
                  edge_total, input ready);
  modport sink   (input valid, result_kind, edge_kind, low_vertex, high_vertex, mismatch,
                  edge_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gesn_ctrl.sv =====
// Controller: sequencing state machine of the edge normalizer.
`default_nettype none
module gesn_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire gesn_pkg::gesn_status_t status,
  output gesn_pkg::gesn_cmd_t        cmd
);
  import gesn_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_SINIT, S_SRD, S_SCMP, S_CHECK, S_REJ, S_ASGS, S_ASGT,
    S_ORDER, S_MUL, S_IDX, S_PRD, S_PMOD, S_END, S_NOMORE, S_FREAD, S_FTEST, S_CONV, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        case (status.func)
          FUNC_UPDATE: state_next = status.ended ? S_IDLE : S_SINIT;
          FUNC_END:    state_next = S_END;
          FUNC_FETCH: begin
            if (status.static_mode && status.ended) begin
              state_next = status.scan_done ? S_NOMORE : S_FREAD;
            end else begin
              state_next = S_IDLE;
            end
          end
          default:     state_next = S_IDLE;
        endcase
      end
      S_SINIT: begin
        cmd.op     = OP_SINIT;
        state_next = S_SRD;
      end
      S_SRD: begin
        cmd.op     = OP_SRD;
        state_next = status.search_done ? S_CHECK : S_SCMP;
      end
      S_SCMP: begin
        cmd.op     = OP_SCMP;
        state_next = S_SRD;
      end
      S_CHECK:  state_next = status.fail ? S_REJ : S_ASGS;
      S_REJ: begin
        cmd.op     = OP_REJECT;
        state_next = S_EMIT;
      end
      S_ASGS: begin
        cmd.op     = OP_ASGS;
        state_next = S_ASGT;
      end
      S_ASGT: begin
        cmd.op     = OP_ASGT;
        state_next = S_ORDER;
      end
      S_ORDER: begin
        cmd.op     = OP_ORDER;
        state_next = status.same ? S_IDLE : S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_IDX;
      end
      S_IDX: begin
        cmd.op     = OP_IDX;
        state_next = S_PRD;
      end
      S_PRD: begin
        cmd.op     = OP_PRD;
        state_next = S_PMOD;
      end
      S_PMOD: begin
        cmd.op     = OP_PMOD;
        state_next = status.static_mode ? S_IDLE : S_EMIT;
      end
      S_END: begin
        cmd.op     = OP_END;
        state_next = S_EMIT;
      end
      S_NOMORE: begin
        cmd.op     = OP_NOMORE;
        state_next = S_EMIT;
      end
      S_FREAD: begin
        cmd.op     = OP_FREAD;
        state_next = S_FTEST;
      end
      S_FTEST: begin
        cmd.op = OP_FTEST;
        if (status.word_hit)      state_next = S_CONV;
        else if (status.row_last) state_next = S_NOMORE;
        else                      state_next = S_FREAD;
      end
      S_CONV: begin
        cmd.op = OP_CONV;
        if (!status.conv_step) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/gesn_dp.sv =====
// Datapath: id table, pair bit store, counters and result register of the edge normalizer.
`default_nettype none
module gesn_dp #(
  parameter int MAX_VERTICES = gesn_pkg::DefMaxVertices,
  parameter int ID_BITS      = gesn_pkg::DefIdBits
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  gesn_in_if.sink                    in_ch,
  gesn_out_if.source                 out_ch,
  input  wire gesn_pkg::gesn_cfg_t   cfg,
  input  wire gesn_pkg::gesn_cmd_t   cmd,
  output gesn_pkg::gesn_status_t     status
);
  import gesn_pkg::*;

  localparam int     N        = MAX_VERTICES;
  localparam int     VW       = (N > 2) ? $clog2(N) : 1;
  localparam int     CW       = $clog2(N + 1);
  localparam int     KW       = (CW > VcountWidth) ? CW : VcountWidth;
  localparam int     IW       = (ID_BITS < RawWidth) ? ID_BITS : RawWidth;
  localparam longint PairTotal = (longint'(N) * longint'(N - 1)) / 2;
  localparam int     PW0      = $clog2(PairTotal + 1);
  localparam int     PW       = (PW0 < WordShift + 1) ? WordShift + 1 : PW0;
  localparam longint PairRows = (PairTotal + WordBits - 1) / WordBits;
  localparam int     RW       = (PairRows > 1) ? $clog2(PairRows) : 1;
  localparam int     MW       = 2 * VW + 1;

  localparam logic [RW-1:0] RowLast  = RW'(PairRows - 1);
  localparam logic [PW-1:0] PairEnd  = PW'(PairTotal);
  localparam logic [VW:0]   TwoNm1   = (VW + 1)'(2 * N - 1);
  localparam logic [CW-1:0] NVert    = CW'(N);

  // Latched item
  logic [1:0]    func;
  logic [1:0]    kind;
  logic [IW-1:0] rs;
  logic [IW-1:0] rt;

  // Id table
  logic [IW-1:0] vmem [N];
  logic [IW-1:0] vrdata;
  logic [CW-1:0] nid;
  logic [CW-1:0] sidx;
  logic          s_found;
  logic          t_found;
  logic [VW-1:0] s_id;
  logic [VW-1:0] t_id;

  // Pair store
  logic [WordBits-1:0] pmem [PairRows];
  logic [WordBits-1:0] prdata;
  logic [RW-1:0]       clr_row;
  logic [RW-1:0]       prow;
  logic [RW-1:0]       scan_row;

  logic [VW-1:0] lo;
  logic [VW-1:0] hi;
  logic [MW-1:0] prod;
  logic [PW-1:0] idx;
  logic [PW-1:0] present;
  logic [TotalWidth-1:0] emitted;
  logic [PW-1:0] scan;
  logic          ended;

  // Fetch position decode
  logic [PW-1:0] fpos;
  logic [PW-1:0] base;
  logic [VW-1:0] flo;

  // Pending result and output register
  logic [1:0]            res_kind;
  logic                  res_ek;
  logic [VW-1:0]         res_lo;
  logic [VW-1:0]         res_hi;
  logic                  res_mis;
  logic [TotalWidth-1:0] res_total;
  logic                  out_valid;

  // Combinational helpers
  logic [1:0]      need;
  logic [KW-1:0]   cap;
  logic [KW-1:0]   nid_k;
  logic            was;
  logic [WordShift-1:0] pbit;
  logic [WordShift-1:0] hit_bit;
  logic            hit;
  logic [PW-1:0]   row_len;
  logic            step;

  assign cap   = (KW'(cfg.vertex_count) < KW'(NVert)) ? KW'(cfg.vertex_count) : KW'(NVert);
  assign nid_k = KW'(nid);
  assign need  = {1'b0, !s_found} + {1'b0, (!t_found && (rt != rs))};

  assign pbit     = idx[WordShift-1:0];
  assign was      = prdata[pbit];
  assign scan_row = RW'(scan >> WordShift);

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (prdata[b] && (WordShift'(b) >= scan[WordShift-1:0])) begin
        hit     = 1'b1;
        hit_bit = WordShift'(b);
      end
    end
  end

  assign row_len = PW'(N - 1) - PW'(flo);
  assign step    = ((CW'(flo) + CW'(1)) < NVert) && ((base + row_len) <= fpos);

  always_comb begin
    status.func        = func;
    status.ended       = ended;
    status.static_mode = cfg.static_mode;
    status.clr_last    = (clr_row == RowLast);
    status.search_done = (sidx >= nid);
    status.fail        = (need != 2'd0) && ((nid_k >= cap) || ((cap - nid_k) < KW'(need)));
    status.same        = (s_id == t_id);
    status.scan_done   = (scan >= PairEnd);
    status.word_hit    = hit;
    status.row_last    = (scan_row == RowLast);
    status.conv_step   = step;
    status.out_free    = !out_valid || out_ch.ready;
  end

  // Id table memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ASGS && !s_found) begin
      vmem[nid[VW-1:0]] <= rs;
    end else if (cmd.op == OP_ASGT && !t_found && (rt != rs)) begin
      vmem[nid[VW-1:0]] <= rt;
    end
    if (cmd.op == OP_SRD) begin
      vrdata <= vmem[sidx[VW-1:0]];
    end
  end

  // Pair store memory: one address per cycle
  always_comb begin
    case (cmd.op)
      OP_CLEAR: prow = clr_row;
      OP_FREAD: prow = scan_row;
      default:  prow = RW'(idx >> WordShift);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) begin
      pmem[prow] <= '0;
    end else if (cmd.op == OP_PMOD) begin
      pmem[prow] <= prdata ^ (WordBits'(1) << pbit);
    end
    if (cmd.op == OP_PRD || cmd.op == OP_FREAD) begin
      prdata <= pmem[prow];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row   <= '0;
      nid       <= '0;
      present   <= '0;
      emitted   <= '0;
      scan      <= '0;
      ended     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr_row <= clr_row + RW'(1);
        OP_ASGS:  if (!s_found) nid <= nid + CW'(1);
        OP_ASGT:  if (!t_found && (rt != rs)) nid <= nid + CW'(1);
        OP_PMOD: begin
          present <= was ? present - PW'(1) : present + PW'(1);
          if (emitted != '1) emitted <= emitted + TotalWidth'(1);
        end
        OP_END: begin
          ended <= 1'b1;
          scan  <= '0;
        end
        OP_FTEST: begin
          if (!hit) begin
            if (scan_row == RowLast) scan <= PairEnd;
            else scan <= PW'(scan_row + RW'(1)) << WordShift;
          end
        end
        OP_CONV:  if (!step) scan <= fpos + PW'(1);
        OP_EMIT:  if (!out_valid || out_ch.ready) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_IDLE: begin
        if (in_ch.valid) begin
          func <= in_ch.func;
          kind <= in_ch.update_kind;
          rs   <= in_ch.raw_source[IW-1:0];
          rt   <= in_ch.raw_target[IW-1:0];
        end
      end
      OP_SINIT: begin
        sidx    <= '0;
        s_found <= 1'b0;
        t_found <= 1'b0;
      end
      OP_SCMP: begin
        if (!s_found && vrdata == rs) begin
          s_found <= 1'b1;
          s_id    <= sidx[VW-1:0];
        end
        if (!t_found && vrdata == rt) begin
          t_found <= 1'b1;
          t_id    <= sidx[VW-1:0];
        end
        sidx <= sidx + CW'(1);
      end
      OP_ASGS: if (!s_found) s_id <= nid[VW-1:0];
      OP_ASGT: begin
        if (!t_found) t_id <= (rt == rs) ? s_id : nid[VW-1:0];
      end
      OP_ORDER: begin
        lo <= (s_id < t_id) ? s_id : t_id;
        hi <= (s_id < t_id) ? t_id : s_id;
      end
      OP_MUL:   prod <= MW'(lo) * MW'(TwoNm1 - (VW + 1)'(lo));
      OP_IDX:   idx  <= PW'(prod >> 1) + PW'(hi) - PW'(lo) - PW'(1);
      OP_REJECT: begin
        res_kind  <= RES_REJECT;
        res_ek    <= 1'b0;
        res_lo    <= '0;
        res_hi    <= '0;
        res_mis   <= 1'b0;
        res_total <= '0;
      end
      OP_PMOD: begin
        res_kind  <= RES_EDGE;
        res_ek    <= was;
        res_lo    <= lo;
        res_hi    <= hi;
        res_mis   <= cfg.check_types && !kind[1] && (kind[0] != was);
        res_total <= '0;
      end
      OP_END: begin
        res_kind  <= RES_SUMMARY;
        res_ek    <= 1'b0;
        res_lo    <= '0;
        res_hi    <= '0;
        res_mis   <= 1'b0;
        res_total <= cfg.static_mode ? TotalWidth'(present) : emitted;
      end
      OP_NOMORE: begin
        res_kind  <= RES_NOMORE;
        res_ek    <= 1'b0;
        res_lo    <= '0;
        res_hi    <= '0;
        res_mis   <= 1'b0;
        res_total <= '0;
      end
      OP_FTEST: begin
        fpos <= (PW'(scan_row) << WordShift) | PW'(hit_bit);
        base <= '0;
        flo  <= '0;
      end
      OP_CONV: begin
        if (step) begin
          base <= base + row_len;
          flo  <= flo + VW'(1);
        end else begin
          res_kind  <= RES_EDGE;
          res_ek    <= 1'b0;
          res_lo    <= flo;
          res_hi    <= VW'(PW'(flo) + PW'(1) + fpos - base);
          res_mis   <= 1'b0;
          res_total <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT && (!out_valid || out_ch.ready)) begin
      out_ch.result_kind <= res_kind;
      out_ch.edge_kind   <= res_ek;
      out_ch.low_vertex  <= OutVxWidth'(res_lo);
      out_ch.high_vertex <= OutVxWidth'(res_hi);
      out_ch.mismatch    <= res_mis;
      out_ch.edge_total  <= res_total;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire

// ===== rtl/core/graph_edge_stream_normalizer_unit.sv =====
// Top level: configuration registers, controller and datapath of the edge normalizer.
// An update searches the id table one entry at a time over the K ids assigned so far,
//   then assigns ids, orders the pair and toggles its bit; end of stream emits a summary.
// A fetch reads one 64-bit pair word at a time until a present edge, then decodes
//   its position row by row into a vertex pair. One item is in work at a time.
// Reset: synchronous, active high; then the pair store is cleared one 64-bit row per
//   cycle (ceil(MAX_VERTICES*(MAX_VERTICES-1)/128) rows, 8184 at default) before input.
`default_nettype none
module graph_edge_stream_normalizer_unit #(
  parameter int MAX_VERTICES = gesn_pkg::DefMaxVertices,
  parameter int ID_BITS      = gesn_pkg::DefIdBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gesn_in_if.sink          in_ch,
  gesn_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gesn_pkg::*;

  gesn_cfg_t    cfg;
  gesn_cmd_t    cmd;
  gesn_status_t status;
  logic         cfg_we;

  // Register file: write on the access phase of an APB transaction
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vertex_count <= VcountReset;
      cfg.static_mode  <= 1'b0;
      cfg.check_types  <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_VCOUNT: cfg.vertex_count <= pwdata[VcountWidth-1:0];
        REG_STATIC: cfg.static_mode  <= pwdata[0];
        REG_CHECK:  cfg.check_types  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VCOUNT: prdata = 32'(cfg.vertex_count);
      REG_STATIC: prdata = 32'(cfg.static_mode);
      REG_CHECK:  prdata = 32'(cfg.check_types);
      default:    prdata = '0;
    endcase
  end

  // Sequence each transaction through the datapath
  gesn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold id table, pair store, counters and the result register
  gesn_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule
`default_nettype wire
